// ----- design/wfs_pkg.sv -----
// shared constants, state encoding and sizes for the wire field superposition core
// no dependencies
`default_nettype none

package wfs_pkg;

   localparam int MAX_WIRES_DEFAULT = 64;

   localparam int COORD_W  = 32;
   localparam int SLOT_W   = 6;
   localparam int FIELD_W  = 48;
   localparam int MAG_W    = 47;
   localparam int ENTRY_W  = 3 * COORD_W;

   // digit-serial multiplier operands
   localparam int MUL_A_W  = 106;
   localparam int MUL_B_W  = 48;
   localparam int MUL_P_W  = 140;
   localparam int MUL_DIG  = 8;

   // term divider operands
   localparam int DIV_N_W  = 104;
   localparam int DIV_D_W  = 66;
   localparam int DIV_Q_W  = 62;
   localparam int TERM_W   = 63;

   // round(2e-7 * 2^64)
   localparam logic [41:0] KCOEF = 42'd3689348814742;
   localparam logic [65:0] NEAR_LIMIT_SQ = 66'd109;
   localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic REG_PERM  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   localparam logic [31:0] PERM_RESET = 32'd65536;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_SQX,
      ST_SQX_W,
      ST_SQY,
      ST_SQY_W,
      ST_MP,
      ST_MP_W,
      ST_MK,
      ST_MK_W,
      ST_NX,
      ST_NX_W,
      ST_DX_W,
      ST_NY,
      ST_NY_W,
      ST_DY_W,
      ST_NEXT,
      ST_MAGX,
      ST_MAGX_W,
      ST_MAGY,
      ST_MAGY_W,
      ST_SQRT,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ----- design/wfs_if.sv -----
// valid/ready channel interfaces for request and response words
// depends on wfs_pkg
`default_nettype none

interface wfs_req_if;
   import wfs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [SLOT_W-1:0]         slot;
   logic signed [COORD_W-1:0] x_pos;
   logic signed [COORD_W-1:0] y_pos;
   logic signed [COORD_W-1:0] current;

   modport source (output valid, command, slot, x_pos, y_pos, current, input ready);
   modport sink   (input valid, command, slot, x_pos, y_pos, current, output ready);
endinterface

interface wfs_rsp_if;
   import wfs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] field_x;
   logic signed [FIELD_W-1:0] field_y;
   logic [MAG_W-1:0]          field_mag;

   modport source (output valid, field_x, field_y, field_mag, input ready);
   modport sink   (input valid, field_x, field_y, field_mag, output ready);
endinterface

`default_nettype wire

// ----- design/wfs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module wfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/wfs_mul.sv -----
// digit-serial multiplier, one 8 bit digit of b per cycle
// depends on wfs_pkg
`default_nettype none

module wfs_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [wfs_pkg::MUL_A_W-1:0]  a,
   input  wire logic [wfs_pkg::MUL_B_W-1:0]  b,
   output logic                              done,
   output logic [wfs_pkg::MUL_P_W-1:0]       product
);
   import wfs_pkg::*;

   localparam int DIGITS = MUL_B_W / MUL_DIG;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [MUL_P_W-1:0]  a_ff, a_in;
   logic [MUL_B_W-1:0]  b_ff, b_in;
   logic [MUL_P_W-1:0]  acc_ff, acc_in;
   logic [MUL_P_W-1:0]  partial;

   always_comb begin
      partial = a_ff * MUL_P_W'(b_ff[MUL_DIG-1:0]);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = MUL_P_W'(a);
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + partial;
         a_in   = a_ff << MUL_DIG;
         b_in   = b_ff >> MUL_DIG;
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'(DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ----- design/wfs_div.sv -----
// restoring divider for one field term: round(num / (2 * den)), clamped to 2^62
// one quotient bit per cycle; depends on wfs_pkg
`default_nettype none

module wfs_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [wfs_pkg::DIV_N_W-1:0]  num,
   input  wire logic [wfs_pkg::DIV_D_W-1:0]  den,
   output logic                              done,
   output logic [wfs_pkg::TERM_W-1:0]        quot
);
   import wfs_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]  rem_ff, rem_in;
   logic [DIV_Q_W-1:0]  bits_ff, bits_in;
   logic [DIV_Q_W-1:0]  q_ff, q_in;
   logic [TERM_W-1:0]   res_ff, res_in;
   logic [DIV_D_W:0]    rem2;
   logic                ge;

   always_comb begin
      rem2    = {rem_ff, bits_ff[DIV_Q_W-1]};
      ge      = rem2 >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      q_in    = q_ff;
      res_in  = res_ff;
      if (start) begin
         // quotient of 2^62 or more saturates without iterating
         if (DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]) >= den) begin
            res_in  = TERM_LIMIT;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]);
            bits_in = num[DIV_Q_W-1:0];
            q_in    = '0;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? DIV_D_W'(rem2 - {1'b0, den}) : rem2[DIV_D_W-1:0];
         bits_in = bits_ff << 1;
         q_in    = {q_ff[DIV_Q_W-2:0], ge};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // round half up from the extra quotient bit
            res_in  = TERM_W'(({1'b0, q_in} + TERM_W'(1)) >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign quot = res_ff;

endmodule

`default_nettype wire

// ----- design/wire_field_superposition_core.sv -----
// wire field superposition core: conductor table in ram, field sum at a point
// load word: written to the table on acceptance, next word taken in the following cycle
// evaluate word: accepted, then per conductor a table read and step, six digit-serial
// multiplies and two divisions (a saturated division skips its iterations); a conductor
// too close skips the rest after its distance; then the magnitude (square root)
// one word is worked on at a time; synchronous active high reset clears control, table undefined
`default_nettype none

module wire_field_superposition_core #(
   parameter int MAX_WIRES = wfs_pkg::MAX_WIRES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   wfs_req_if.sink           req_chan,
   wfs_rsp_if.source         rsp_chan,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import wfs_pkg::*;

   localparam int AW = (MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1;
   localparam int CW = $clog2(MAX_WIRES + 1);
   localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

   function automatic logic signed [FIELD_W-1:0] sat_add(
      input logic signed [FIELD_W-1:0] acc,
      input logic                      neg,
      input logic [TERM_W-1:0]         mag
   );
      logic signed [63:0] s;
      logic signed [63:0] m;
      begin
         m = $signed({1'b0, mag});
         s = neg ? (64'(acc) - m) : (64'(acc) + m);
         if (s > OUT_MAX) begin
            s = OUT_MAX;
         end
         if (s < OUT_MIN) begin
            s = OUT_MIN;
         end
         return FIELD_W'(s);
      end
   endfunction

   state_type state_ff, state_in;

   logic [31:0]               perm_ff;
   logic [6:0]                count_ff;

   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [CW-1:0]             n_ff, n_in, idx_ff, idx_in;
   logic [31:0]               adx_ff, adx_in, ady_ff, ady_in, ac_ff, ac_in;
   logic                      sx_ff, sx_in, sy_ff, sy_in, sc_ff, sc_in;
   logic [63:0]               sqx_ff, sqx_in;
   logic [DIV_D_W-1:0]        d2_ff, d2_in;
   logic [MUL_A_W-1:0]        pk_ff, pk_in;
   logic signed [FIELD_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [95:0]               sum_ff, sum_in;
   logic [47:0]               root_ff, root_in;
   logic [49:0]               rem_ff, rem_in;
   logic [5:0]                sq_cnt_ff, sq_cnt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_W-1:0] rsp_fx_ff, rsp_fx_in, rsp_fy_ff, rsp_fy_in;
   logic [MAG_W-1:0]          rsp_mag_ff, rsp_mag_in;

   // ram and arithmetic unit hookup
   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic                mul_start, mul_done;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  mul_p;
   logic                div_start, div_done;
   logic [DIV_N_W-1:0]  div_num;
   logic [TERM_W-1:0]   div_q;

   logic                      req_fire;
   logic [CW-1:0]             n_val;
   logic signed [COORD_W-1:0] rd_x, rd_y, rd_c;
   logic signed [COORD_W:0]   dx_w, dy_w, c_w;
   logic [DIV_D_W-1:0]        d2_w;
   logic [FIELD_W-1:0]        afx, afy;
   logic [51:0]               sq_rem2;
   logic [51:0]               sq_trial;
   logic                      sq_ge;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rd_x = $signed(ram_rdata[3*COORD_W-1:2*COORD_W]);
   assign rd_y = $signed(ram_rdata[2*COORD_W-1:COORD_W]);
   assign rd_c = $signed(ram_rdata[COORD_W-1:0]);

   assign afx = fx_ff[FIELD_W-1] ? FIELD_W'(-fx_ff) : FIELD_W'(fx_ff);
   assign afy = fy_ff[FIELD_W-1] ? FIELD_W'(-fy_ff) : FIELD_W'(fy_ff);

   wfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIRES),
      .AW    (AW)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_chan.x_pos, req_chan.y_pos, req_chan.current}),
      .re    (ram_re),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   wfs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   wfs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (d2_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // term numerator is the product scaled down by 2^35
   assign div_num = DIV_N_W'(mul_p >> 35);

   always_comb begin
      if (32'(count_ff) > 32'(MAX_WIRES)) begin
         n_val = CW'(MAX_WIRES);
      end else begin
         n_val = CW'(count_ff);
      end
   end

   always_comb begin
      dx_w = (COORD_W+1)'(px_ff) - (COORD_W+1)'(rd_x);
      dy_w = (COORD_W+1)'(py_ff) - (COORD_W+1)'(rd_y);
      c_w  = (COORD_W+1)'(rd_c);
      d2_w = DIV_D_W'(sqx_ff) + DIV_D_W'(mul_p[63:0]);
      sq_rem2  = {rem_ff, sum_ff[95:94]};
      sq_trial = 52'({root_ff, 2'b01});
      sq_ge    = sq_rem2 >= sq_trial;

      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      ac_in        = ac_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sc_in        = sc_ff;
      sqx_in       = sqx_ff;
      d2_in        = d2_ff;
      pk_in        = pk_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      sq_cnt_in    = sq_cnt_ff;
      rsp_fx_in    = rsp_fx_ff;
      rsp_fy_in    = rsp_fy_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      ram_we    = 1'b0;
      ram_waddr = AW'(req_chan.slot);
      ram_re    = 1'b0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == CMD_LOAD) begin
                  ram_we = (32'(req_chan.slot) < 32'(MAX_WIRES));
               end else begin
                  px_in  = req_chan.x_pos;
                  py_in  = req_chan.y_pos;
                  n_in   = n_val;
                  idx_in = '0;
                  fx_in  = '0;
                  fy_in  = '0;
                  state_in = (n_val == '0) ? ST_MAGX : ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            sx_in  = dx_w[COORD_W];
            sy_in  = dy_w[COORD_W];
            sc_in  = c_w[COORD_W];
            adx_in = dx_w[COORD_W] ? COORD_W'(-dx_w) : dx_w[COORD_W-1:0];
            ady_in = dy_w[COORD_W] ? COORD_W'(-dy_w) : dy_w[COORD_W-1:0];
            ac_in  = c_w[COORD_W] ? COORD_W'(-c_w) : c_w[COORD_W-1:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(adx_ff);
            mul_b     = MUL_B_W'(adx_ff);
            state_in  = ST_SQX_W;
         end
         ST_SQX_W: begin
            if (mul_done) begin
               sqx_in   = mul_p[63:0];
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(ady_ff);
            mul_b     = MUL_B_W'(ady_ff);
            state_in  = ST_SQY_W;
         end
         ST_SQY_W: begin
            if (mul_done) begin
               d2_in = d2_w;
               // conductor within 1e-5 m adds nothing
               state_in = (d2_w <= NEAR_LIMIT_SQ) ? ST_NEXT : ST_MP;
            end
         end
         ST_MP: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(perm_ff);
            mul_b     = MUL_B_W'(ac_ff);
            state_in  = ST_MP_W;
         end
         ST_MP_W: begin
            if (mul_done) begin
               pk_in    = MUL_A_W'(mul_p[63:0]);
               state_in = ST_MK;
            end
         end
         ST_MK: begin
            mul_start = 1'b1;
            mul_a     = pk_ff;
            mul_b     = MUL_B_W'(KCOEF);
            state_in  = ST_MK_W;
         end
         ST_MK_W: begin
            if (mul_done) begin
               pk_in    = mul_p[MUL_A_W-1:0];
               state_in = ST_NX;
            end
         end
         ST_NX: begin
            mul_start = 1'b1;
            mul_a     = pk_ff;
            mul_b     = MUL_B_W'(ady_ff);
            state_in  = ST_NX_W;
         end
         ST_NX_W: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DX_W;
            end
         end
         ST_DX_W: begin
            if (div_done) begin
               fx_in    = sat_add(fx_ff, sc_ff == sy_ff, div_q);
               state_in = ST_NY;
            end
         end
         ST_NY: begin
            mul_start = 1'b1;
            mul_a     = pk_ff;
            mul_b     = MUL_B_W'(adx_ff);
            state_in  = ST_NY_W;
         end
         ST_NY_W: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DY_W;
            end
         end
         ST_DY_W: begin
            if (div_done) begin
               fy_in    = sat_add(fy_ff, sc_ff != sx_ff, div_q);
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if ((idx_ff + CW'(1)) == n_ff) begin
               state_in = ST_MAGX;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_READ;
            end
         end
         ST_MAGX: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(afx);
            mul_b     = MUL_B_W'(afx);
            state_in  = ST_MAGX_W;
         end
         ST_MAGX_W: begin
            if (mul_done) begin
               sum_in   = mul_p[95:0];
               state_in = ST_MAGY;
            end
         end
         ST_MAGY: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(afy);
            mul_b     = MUL_B_W'(afy);
            state_in  = ST_MAGY_W;
         end
         ST_MAGY_W: begin
            if (mul_done) begin
               sum_in    = sum_ff + mul_p[95:0];
               root_in   = '0;
               rem_in    = '0;
               sq_cnt_in = '0;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // two radicand bits per step, one root bit
            rem_in    = sq_ge ? 50'(sq_rem2 - sq_trial) : 50'(sq_rem2);
            root_in   = {root_ff[46:0], sq_ge};
            sum_in    = sum_ff << 2;
            sq_cnt_in = sq_cnt_ff + 6'd1;
            if (sq_cnt_ff == 6'd47) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fx_in    = fx_ff;
               rsp_fy_in    = fy_ff;
               rsp_mag_in   = root_ff[47] ? {MAG_W{1'b1}} : root_ff[MAG_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         idx_ff       <= '0;
         sq_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         sq_cnt_ff    <= sq_cnt_in;
      end
      px_ff      <= px_in;
      py_ff      <= py_in;
      adx_ff     <= adx_in;
      ady_ff     <= ady_in;
      ac_ff      <= ac_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      sc_ff      <= sc_in;
      sqx_ff     <= sqx_in;
      d2_ff      <= d2_in;
      pk_ff      <= pk_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      sum_ff     <= sum_in;
      root_ff    <= root_in;
      rem_ff     <= rem_in;
      rsp_fx_ff  <= rsp_fx_in;
      rsp_fy_ff  <= rsp_fy_in;
      rsp_mag_ff <= rsp_mag_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         perm_ff  <= PERM_RESET;
         count_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_PERM:  perm_ff  <= pwdata;
            REG_COUNT: count_ff <= pwdata[6:0];
            default:   perm_ff  <= perm_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_COUNT) ? {25'd0, count_ff} : perm_ff;
   assign pready = 1'b1;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.field_x   = rsp_fx_ff;
   assign rsp_chan.field_y   = rsp_fy_ff;
   assign rsp_chan.field_mag = rsp_mag_ff;

endmodule

`default_nettype wire

// ----- test/wfs_checker.sv -----
// checker for the wire field superposition core: watches the request, response
// and register ports, predicts each field word and compares. depends on wfs_pkg, wfs_if
`timescale 1ns / 100ps

module wfs_checker (
   input  logic  clock,
   input  logic  reset,
   wfs_req_if    req,
   wfs_rsp_if    rsp,
   input  logic  psel,
   input  logic  penable,
   input  logic  pwrite,
   input  logic  [2:0] paddr,
   input  logic  [31:0] pwdata,
   output int    errors,
   output int    pending,
   output int    checked
);
   import wfs_pkg::*;

   typedef struct packed {
      logic signed [FIELD_W-1:0] fx;
      logic signed [FIELD_W-1:0] fy;
      logic [MAG_W-1:0]          mag;
   } field_t;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] cur;
   } wire_t;

   localparam longint SUM_MAX = 64'sd140737488355327;
   localparam longint SUM_MIN = -64'sd140737488355328;

   wire_t       wires [64];
   logic [31:0] perm;
   logic [6:0]  count;
   field_t      field_q [$];

   // magnitude of one contribution: pk * ad / (2^36 * d2), rounded, clamped to 2^62
   function automatic logic [TERM_W-1:0] term_mag(logic [191:0] pk, logic [191:0] ad,
                                                  logic [191:0] d2);
      logic [191:0] num, q;
      num = (pk * ad) >> 35;
      q = num / d2;
      if (q >= (192'd1 << 62)) return TERM_LIMIT;
      q = (q + 1) >> 1;
      if (q > 192'(TERM_LIMIT)) return TERM_LIMIT;
      return q[TERM_W-1:0];
   endfunction

   function automatic longint sum_sat(longint acc, logic neg, logic [TERM_W-1:0] mag);
      longint t;
      t = longint'({1'b0, mag});
      acc = neg ? acc - t : acc + t;
      if (acc > SUM_MAX) acc = SUM_MAX;
      if (acc < SUM_MIN) acc = SUM_MIN;
      return acc;
   endfunction

   function automatic field_t field_at(logic signed [31:0] px, logic signed [31:0] py);
      field_t       f;
      longint       sx, sy, dx, dy, cur, adx, ady, acur, ax, ay;
      logic [191:0] d2, pk;
      logic [127:0] s, r, t;
      int           n;
      sx = 0;
      sy = 0;
      n = (count > 64) ? 64 : int'(count);
      for (int i = 0; i < n; i++) begin
         dx = longint'(px) - longint'(wires[i].x);
         dy = longint'(py) - longint'(wires[i].y);
         cur = longint'(wires[i].cur);
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         acur = cur < 0 ? -cur : cur;
         d2 = 192'(adx) * 192'(adx) + 192'(ady) * 192'(ady);
         if (d2 <= 192'(NEAR_LIMIT_SQ)) continue;
         pk = 192'(perm) * 192'(acur) * 192'(KCOEF);
         sx = sum_sat(sx, (cur < 0) == (dy < 0), term_mag(pk, 192'(ady), d2));
         sy = sum_sat(sy, (cur < 0) != (dx < 0), term_mag(pk, 192'(adx), d2));
      end
      ax = sx < 0 ? -sx : sx;
      ay = sy < 0 ? -sy : sy;
      s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      r = 0;
      for (int b = 47; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= s) r = t;
      end
      if (r > 128'h7FFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF;
      f.fx = sx[FIELD_W-1:0];
      f.fy = sy[FIELD_W-1:0];
      f.mag = r[MAG_W-1:0];
      return f;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      field_t want;
      if (reset) begin
         perm <= PERM_RESET;
         count <= '0;
      end else begin
         if (psel && penable && pwrite) begin
            if (paddr[2] == REG_PERM) perm <= pwdata;
            else count <= pwdata[6:0];
         end
         if (req.valid && req.ready) begin
            if (req.command == CMD_LOAD)
               wires[req.slot] <= '{req.x_pos, req.y_pos, req.current};
            else
               field_q.push_back(field_at(req.x_pos, req.y_pos));
         end
         if (rsp.valid && rsp.ready) begin
            if (field_q.size() == 0) begin
               report("unexpected word", {16'd0, rsp.field_x}, 64'd0);
            end else begin
               want = field_q.pop_front();
               checked++;
               if (rsp.field_x !== want.fx) report("field_x", 64'(rsp.field_x), 64'(want.fx));
               if (rsp.field_y !== want.fy) report("field_y", 64'(rsp.field_y), 64'(want.fy));
               if (rsp.field_mag !== want.mag)
                  report("field_mag", 64'(rsp.field_mag), 64'(want.mag));
            end
         end
      end
   end

   assign pending = field_q.size();

   initial begin
      errors = 0;
      checked = 0;
   end

endmodule

// ----- test/wire_field_superposition_core_tb.sv -----
// testbench top for wire_field_superposition_core: loads conductors, evaluates
// points under several idle patterns and register settings. depends on wfs_pkg, wfs_if, wfs_checker
`timescale 1ns / 100ps

module wire_field_superposition_core_tb;
   import wfs_pkg::*;

   localparam int IDLE_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          errors, pending, checked;
   int          send_idle, stall_pct, quiet_cycles;
   int          words_sent, evals_sent;
   logic signed [31:0] slot_x [64];
   logic signed [31:0] slot_y [64];

   wfs_req_if req_bus();
   wfs_rsp_if rsp_bus();

   wire_field_superposition_core u_dut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   wfs_checker u_checker (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .errors(errors), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no handshake or register access anywhere
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic csr_write(logic idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(logic cmd, logic [5:0] slot, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] cur);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.slot <= slot;
      req_bus.x_pos <= x;
      req_bus.y_pos <= y;
      req_bus.current <= cur;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (cmd == CMD_EVAL) evals_sent++;
      else begin
         slot_x[slot] = x;
         slot_y[slot] = y;
      end
   endtask

   // block must be idle before a register write
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000);
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   task automatic random_word(int count);
      logic [5:0]  s;
      logic [31:0] offs;
      if ($urandom_range(99) < 65) begin
         send_word(CMD_LOAD, 6'($urandom_range(63)), rand_coord(), rand_coord(),
                   ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(1 << 22)) - (1 << 21)));
      end else if (count > 0 && $urandom_range(2) == 0) begin
         // close to a conductor in the sum, sometimes right on it
         s = 6'($urandom_range(count > 64 ? 63 : count - 1));
         offs = $urandom_range(1) ? 32'($urandom_range(24)) - 12 : 32'($urandom_range(4000)) - 2000;
         send_word(CMD_EVAL, 6'($urandom_range(63)), slot_x[s] + offs,
                   slot_y[s] - 32'($urandom_range(20)), $urandom);
      end else
         send_word(CMD_EVAL, 6'($urandom_range(63)), rand_coord(), rand_coord(), $urandom);
   endtask

   initial begin
      int counts [4];
      reset = 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_LOAD;
      req_bus.slot <= '0;
      req_bus.x_pos <= '0;
      req_bus.y_pos <= '0;
      req_bus.current <= '0;
      send_idle = 0;
      stall_pct = 0;
      quiet_cycles = 0;
      words_sent = 0;
      evals_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every slot gets written so any count is legal
      for (int i = 0; i < 64; i++)
         send_word(CMD_LOAD, 6'(i), rand_coord(), rand_coord(), $urandom);

      // directed: zero sum, extremes, near conductor, saturation
      send_word(CMD_EVAL, 0, 0, 0, 0);
      send_word(CMD_LOAD, 0, 0, 0, 32'h7FFF_FFFF);
      send_word(CMD_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(CMD_LOAD, 2, 100, 0, 32'h0001_0000);
      send_word(CMD_LOAD, 3, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000);
      drain();
      csr_write(REG_COUNT, 4);
      send_word(CMD_EVAL, 63, 5, 5, 0);
      send_word(CMD_EVAL, 0, 10, 0, 0);
      send_word(CMD_EVAL, 0, 11, 0, 0);
      send_word(CMD_EVAL, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_word(CMD_EVAL, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_word(CMD_EVAL, 0, -3000, 4000, 0);
      drain();
      csr_write(REG_PERM, 32'hFFFF_FFFF);
      send_word(CMD_EVAL, 0, 1000, 1000, 0);
      send_word(CMD_EVAL, 0, 120, 3, 0);
      drain();
      csr_write(REG_PERM, 0);
      csr_write(REG_COUNT, 64);
      send_word(CMD_EVAL, 0, 7, 7, 0);
      drain();
      csr_write(REG_PERM, PERM_RESET);
      csr_write(REG_COUNT, 127);
      send_word(CMD_EVAL, 0, 12345, -999, 0);
      drain();

      // random phases: none, sender idle, receiver stall, both
      counts = '{0, 73, 0, 31};
      for (int ph = 0; ph < 4; ph++) begin
         int cnt;
         send_idle = counts[ph];
         stall_pct = (ph == 2) ? 73 : (ph == 3) ? 31 : 0;
         for (int sub = 0; sub < 3; sub++) begin
            cnt = $urandom_range(1, 6);
            if (sub == 0) cnt = 0;
            csr_write(REG_COUNT, 32'(cnt));
            csr_write(REG_PERM, (sub == 2) ? $urandom : 32'($urandom_range(1 << 20)));
            repeat (140) random_word(cnt);
            drain();
         end
         // one widest setting per phase
         csr_write(REG_COUNT, (ph % 2) ? 127 : 64);
         csr_write(REG_PERM, (ph % 2) ? 32'hFFFF_FFFF : $urandom);
         repeat (3) random_word(64);
         drain();
      end

      $display("sent %0d request words (%0d evaluations), %0d field words checked",
               words_sent, evals_sent, checked);
      $display("covered counts 0 to 127, permeability extremes and four idle patterns");
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/wfs_pkg.sv
design/wfs_if.sv
design/wfs_ram.sv
design/wfs_mul.sv
design/wfs_div.sv
design/wire_field_superposition_core.sv
test/wfs_checker.sv
test/wire_field_superposition_core_tb.sv
